[rtl/htd_pkg.sv]
`timescale 1ns / 1ps

package htd_pkg;

    // defaults for the top level parameters
    localparam int MAX_NODES_DEF    = 512;
    localparam int SYMBOL_BITS_DEF  = 16;
    localparam int MAX_CODE_LEN_DEF = 32;

    // fixed field geometry
    localparam int CODE_W = 32;
    localparam int BYTE_W = 8;
    localparam int OSYM_W = 16;

    typedef enum logic [2:0] {
        ST_SYMBOL  = 3'd0,
        ST_LOADED  = 3'd1,
        ST_FULL    = 3'd2,
        ST_BADPATH = 3'd3,
        ST_EMPTY   = 3'd4
    } status_e_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_STEP,
        S_LD_LINK,
        S_DC_STEP,
        S_DC_CHK,
        S_END
    } state_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] symbol_value;
        logic [31:0] code_bits;
        logic [5:0]  code_length;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0] decoded_symbol;
        status_e_t   status;
        logic        last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic      capture;
        logic      descend;
        logic      alloc;
        logic      link;
        logic      mark_leaf;
        logic      go_root;
        logic      skip_bit;
        logic      save_walk;
        logic      emit;
        status_e_t emit_status;
        logic      flush;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic cnt_zero;
        logic bcnt_zero;
        logic child_zero;
        logic leaf;
        logic table_full;
        logic pend_valid;
        logic out_free;
    } stat_t;

endpackage

[rtl/htd_ram.sv]
`timescale 1ns / 1ps

module htd_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/htd_ctrl.sv]
`timescale 1ns / 1ps

module htd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  logic          item_kind,
    output logic          item_stall,
    output htd_pkg::cmd_t cmd,
    input  htd_pkg::stat_t st
);

    import htd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   can_emit;

    // a new result may enter the pending slot once the old one can move on
    assign can_emit = !st.pend_valid || st.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit_status = ST_SYMBOL;
        item_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = item_kind ? S_DC_STEP : S_LD_STEP;
                end
            end
            S_LD_STEP:
            begin
                if (st.empty)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_EMPTY;
                    state_next      = S_END;
                end
                else if (st.cnt_zero)
                begin
                    cmd.mark_leaf   = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_LOADED;
                    state_next      = S_END;
                end
                else if (!st.child_zero)
                begin
                    cmd.descend = 1'b1;
                end
                else if (st.table_full)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_FULL;
                    state_next      = S_END;
                end
                else
                begin
                    cmd.alloc  = 1'b1;
                    state_next = S_LD_LINK;
                end
            end
            S_LD_LINK:
            begin
                cmd.link   = 1'b1;
                state_next = S_LD_STEP;
            end
            S_DC_STEP:
            begin
                if (st.bcnt_zero)
                begin
                    cmd.save_walk = 1'b1;
                    state_next    = S_END;
                end
                else if (st.child_zero)
                begin
                    if (can_emit)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_BADPATH;
                        cmd.go_root     = 1'b1;
                        cmd.skip_bit    = 1'b1;
                    end
                end
                else
                begin
                    cmd.descend = 1'b1;
                    state_next  = S_DC_CHK;
                end
            end
            S_DC_CHK:
            begin
                if (!st.leaf)
                begin
                    state_next = S_DC_STEP;
                end
                else if (can_emit)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_SYMBOL;
                    cmd.go_root     = 1'b1;
                    state_next      = S_DC_STEP;
                end
            end
            S_END:
            begin
                if (!st.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/htd_dpath.sv]
`timescale 1ns / 1ps

module htd_dpath #(
    parameter int MAX_NODES    = htd_pkg::MAX_NODES_DEF,
    parameter int SYMBOL_BITS  = htd_pkg::SYMBOL_BITS_DEF,
    parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  htd_pkg::in_item_t  item,
    input  htd_pkg::cmd_t      cmd,
    output htd_pkg::stat_t     st,
    output logic               result_valid,
    input  logic               result_stall,
    output htd_pkg::out_item_t result
);

    import htd_pkg::*;

    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int USED_W = $clog2(MAX_NODES + 1);
    localparam int CNT_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int SYM_W  = SYMBOL_BITS;

    typedef struct packed {
        logic             leaf;
        logic [SYM_W-1:0] sym;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
    } entry_t;

    localparam int ENT_W = $bits(entry_t);

    // control state
    logic [USED_W-1:0] used_reg, used_next;
    logic [IDX_W-1:0]  walk_reg, walk_next;
    entry_t            root_reg, root_next;
    logic              use_ram_reg, use_ram_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic              kind_reg, kind_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              empty_reg, empty_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [3:0]        bcnt_reg, bcnt_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [OSYM_W-1:0] pend_sym_reg, pend_sym_next;
    status_e_t         pend_status_reg, pend_status_next;
    out_item_t         out_reg, out_next;

    // node table port
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    entry_t           entry;
    entry_t           link_entry;
    entry_t           leaf_entry;
    logic [6:0]       pos7;
    logic             lbit;
    logic             dbit;
    logic             sel_bit;
    logic [IDX_W-1:0] nxt;
    logic [IDX_W-1:0] new_idx;
    logic [6:0]       len_ext;
    logic [CNT_W-1:0] len_sat;

    htd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_NODES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // root lives in flops, every other node in the table
    assign entry   = use_ram_reg ? entry_t'(ram_rdata) : root_reg;
    assign new_idx = used_reg[IDX_W-1:0];

    assign pos7    = 7'(cnt_reg) - 7'd1;
    assign lbit    = (pos7 < 7'd32) ? code_reg[pos7[4:0]] : 1'b0;
    assign dbit    = byte_reg[3'(bcnt_reg - 4'd1)];
    assign sel_bit = kind_reg ? dbit : lbit;
    assign nxt     = sel_bit ? entry.right : entry.left;

    assign len_ext = 7'(item.code_length);
    assign len_sat = (len_ext > 7'(MAX_CODE_LEN)) ? CNT_W'(MAX_CODE_LEN)
                                                  : CNT_W'(item.code_length);

    always_comb
    begin
        link_entry = entry;
        if (lbit)
        begin
            link_entry.right = new_idx;
        end
        else
        begin
            link_entry.left = new_idx;
        end
        leaf_entry      = entry;
        leaf_entry.leaf = 1'b1;
        leaf_entry.sym  = sym_reg;
    end

    always_comb
    begin
        st.empty      = empty_reg;
        st.cnt_zero   = (cnt_reg == '0);
        st.bcnt_zero  = (bcnt_reg == 4'd0);
        st.child_zero = (nxt == '0);
        st.leaf       = entry.leaf;
        st.table_full = (used_reg == USED_W'(MAX_NODES));
        st.pend_valid = pend_valid_reg;
        st.out_free   = !out_valid_reg || !result_stall;
    end

    always_comb
    begin
        used_next        = used_reg;
        walk_next        = walk_reg;
        root_next        = root_reg;
        use_ram_next     = use_ram_reg;
        pend_valid_next  = pend_valid_reg;
        out_valid_next   = out_valid_reg;
        kind_next        = kind_reg;
        sym_next         = sym_reg;
        code_next        = code_reg;
        empty_next       = empty_reg;
        cnt_next         = cnt_reg;
        byte_next        = byte_reg;
        bcnt_next        = bcnt_reg;
        cur_next         = cur_reg;
        pend_sym_next    = pend_sym_reg;
        pend_status_next = pend_status_reg;
        out_next         = out_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_re           = 1'b0;
        ram_raddr        = '0;

        if (cmd.capture)
        begin
            kind_next  = item.kind;
            sym_next   = SYM_W'(item.symbol_value);
            code_next  = item.code_bits;
            empty_next = (item.code_length == 6'd0);
            cnt_next   = len_sat;
            byte_next  = item.data_byte;
            bcnt_next  = 4'd8;
            if (item.kind)
            begin
                cur_next     = walk_reg;
                use_ram_next = (walk_reg != '0);
                ram_re       = 1'b1;
                ram_raddr    = walk_reg;
            end
            else
            begin
                cur_next     = '0;
                use_ram_next = 1'b0;
            end
        end

        if (cmd.descend)
        begin
            ram_re       = 1'b1;
            ram_raddr    = nxt;
            cur_next     = nxt;
            use_ram_next = 1'b1;
            if (kind_reg)
            begin
                bcnt_next = bcnt_reg - 4'd1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end

        if (cmd.alloc)
        begin
            ram_we    = 1'b1;
            ram_waddr = new_idx;
            ram_wdata = '0;
        end

        if (cmd.link)
        begin
            if (cur_reg == '0)
            begin
                root_next = link_entry;
            end
            else
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = link_entry;
            end
            ram_re       = 1'b1;
            ram_raddr    = new_idx;
            cur_next     = new_idx;
            use_ram_next = 1'b1;
            used_next    = used_reg + USED_W'(1);
            cnt_next     = cnt_reg - CNT_W'(1);
        end

        if (cmd.mark_leaf)
        begin
            if (cur_reg == '0)
            begin
                root_next = leaf_entry;
            end
            else
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = leaf_entry;
            end
        end

        if (cmd.go_root)
        begin
            cur_next     = '0;
            use_ram_next = 1'b0;
        end

        if (cmd.skip_bit)
        begin
            bcnt_next = bcnt_reg - 4'd1;
        end

        if (cmd.save_walk)
        begin
            walk_next = cur_reg;
        end

        // output register
        if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end

        // hold one result back so the final one can carry last
        if (cmd.emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next          = 1'b1;
                out_next.decoded_symbol = pend_sym_reg;
                out_next.status         = pend_status_reg;
                out_next.last           = 1'b0;
            end
            pend_valid_next  = 1'b1;
            pend_status_next = cmd.emit_status;
            pend_sym_next    = (cmd.emit_status == ST_SYMBOL) ? OSYM_W'(entry.sym) : '0;
        end

        if (cmd.flush)
        begin
            out_valid_next          = 1'b1;
            out_next.decoded_symbol = pend_sym_reg;
            out_next.status         = pend_status_reg;
            out_next.last           = 1'b1;
            pend_valid_next         = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= USED_W'(1);
            walk_reg       <= '0;
            root_reg       <= '0;
            use_ram_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            used_reg       <= used_next;
            walk_reg       <= walk_next;
            root_reg       <= root_next;
            use_ram_reg    <= use_ram_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        sym_reg         <= sym_next;
        code_reg        <= code_next;
        empty_reg       <= empty_next;
        cnt_reg         <= cnt_next;
        byte_reg        <= byte_next;
        bcnt_reg        <= bcnt_next;
        cur_reg         <= cur_next;
        pend_sym_reg    <= pend_sym_next;
        pend_status_reg <= pend_status_next;
        out_reg         <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

[rtl/huffman_tree_bit_decoder.sv]
`timescale 1ns / 1ps

// load item: existing nodes descended in the step state, each new node allocated then linked
// decode item: one node-table read per tree step through the single read port
// next item taken the cycle after the previous one moves its last result to the output register
// results leave through a one-deep output register, one transfer per cycle at most
// reset (rst_n low, asynchronous): root emptied, node count back to 1, walk back to the root

module huffman_tree_bit_decoder #(
    parameter int MAX_NODES    = htd_pkg::MAX_NODES_DEF,
    parameter int SYMBOL_BITS  = htd_pkg::SYMBOL_BITS_DEF,
    parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  htd_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output htd_pkg::out_item_t result
);

    import htd_pkg::*;

    cmd_t  cmd;
    stat_t st;

    // sequencer: walks one tree step per visit of its step states
    htd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_kind  (item.kind),
        .item_stall (item_stall),
        .cmd        (cmd),
        .st         (st)
    );

    // node table, root flops, counters, pending result and output register
    htd_dpath #(
        .MAX_NODES    (MAX_NODES),
        .SYMBOL_BITS  (SYMBOL_BITS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .st           (st),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef SYNTHESIS
    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input taken while previous item still running");

    // only symbol results carry a symbol
    a_symbol_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != ST_SYMBOL) |-> result.decoded_symbol == '0)
        else $error("non-symbol result with nonzero symbol");

    // never allocate into a full table
    a_alloc_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |-> !st.table_full)
        else $error("node allocated past capacity");

    // table port users are exclusive
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.descend, cmd.alloc, cmd.link, cmd.mark_leaf}))
        else $error("node table port contention");
`endif

endmodule

[sim/tb_huffman_tree_bit_decoder.sv]
`timescale 1ns / 1ps

module tb_huffman_tree_bit_decoder;

    import htd_pkg::*;

    // item kinds on the input channel
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    // receiver hold-off length and watchdog limit, in cycles
    localparam int HOLD_CYCLES = 250;
    localparam int QUIET_LIMIT = 3000;
    // cycles allowed for the block to settle once nothing is pending
    localparam int TAIL_CYCLES = 60;

    // code tree mirror: predicts every result of each accepted input transfer
    class code_tree_tracker;
        bit          is_leaf     [MAX_NODES_DEF];
        logic [15:0] leaf_symbol [MAX_NODES_DEF];
        int unsigned left_child  [MAX_NODES_DEF];
        int unsigned right_child [MAX_NODES_DEF];
        int unsigned nodes_in_use;
        int unsigned walk_node;
        out_item_t   expected_results [$];
        int          mismatches;
        int          items_taken;
        int          loads_done;
        int          empties_seen;
        int          full_seen;
        int          symbols_seen;
        int          bad_paths_seen;

        function new();
            for (int n = 0; n < MAX_NODES_DEF; n++)
                clear_node(n);
            nodes_in_use   = 1;
            walk_node      = 0;
            mismatches     = 0;
            items_taken    = 0;
            loads_done     = 0;
            empties_seen   = 0;
            full_seen      = 0;
            symbols_seen   = 0;
            bad_paths_seen = 0;
        endfunction

        function void clear_node(int unsigned n);
            is_leaf[n]     = 1'b0;
            leaf_symbol[n] = '0;
            left_child[n]  = 0;
            right_child[n] = 0;
        endfunction

        function out_item_t make_result(logic [15:0] sym, status_e_t st);
            out_item_t r;
            r.decoded_symbol = sym;
            r.status         = st;
            r.last           = 1'b0;
            return r;
        endfunction

        // note one accepted input transfer and queue the results it causes
        function void take_item(in_item_t it);
            out_item_t   batch [$];
            int unsigned len;
            int unsigned cur;
            int unsigned nxt;
            int unsigned pos;
            int unsigned i;
            int          k;
            bit          b;
            bit          stopped;
            items_taken++;
            if (it.kind == KIND_LOAD)
            begin
                len = 32'(it.code_length);
                if (len == 0)
                begin
                    batch = {batch, make_result('0, ST_EMPTY)};
                    empties_seen++;
                end
                else
                begin
                    // overlong codes saturate
                    if (len > MAX_CODE_LEN_DEF)
                        len = MAX_CODE_LEN_DEF;
                    cur     = 0;
                    stopped = 1'b0;
                    for (i = 0; i < len && !stopped; i++)
                    begin
                        pos = len - 1 - i;
                        b   = (pos < CODE_W) ? it.code_bits[pos] : 1'b0;
                        nxt = b ? right_child[cur] : left_child[cur];
                        if (nxt == 0)
                        begin
                            if (nodes_in_use >= MAX_NODES_DEF)
                                stopped = 1'b1;
                            else
                            begin
                                nxt = nodes_in_use;
                                clear_node(nxt);
                                if (b)
                                    right_child[cur] = nxt;
                                else
                                    left_child[cur] = nxt;
                                nodes_in_use++;
                            end
                        end
                        if (!stopped)
                            cur = nxt;
                    end
                    if (stopped)
                    begin
                        batch = {batch, make_result('0, ST_FULL)};
                        full_seen++;
                    end
                    else
                    begin
                        // final node becomes a leaf even if it has children
                        is_leaf[cur]     = 1'b1;
                        leaf_symbol[cur] = it.symbol_value;
                        batch = {batch, make_result('0, ST_LOADED)};
                        loads_done++;
                    end
                end
            end
            else
            begin
                cur = walk_node;
                for (k = BYTE_W - 1; k >= 0; k--)
                begin
                    b   = it.data_byte[k];
                    nxt = b ? right_child[cur] : left_child[cur];
                    if (nxt == 0)
                    begin
                        batch = {batch, make_result('0, ST_BADPATH)};
                        bad_paths_seen++;
                        cur = 0;
                    end
                    else if (is_leaf[nxt])
                    begin
                        batch = {batch, make_result(leaf_symbol[nxt], ST_SYMBOL)};
                        symbols_seen++;
                        cur = 0;
                    end
                    else
                        cur = nxt;
                end
                walk_node = cur;
            end
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            expected_results = {expected_results, batch};
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("%0t mismatch: %s", $time, msg);
        endtask

        // compare one accepted result transfer with the oldest expectation
        task match_result(out_item_t got);
            out_item_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result symbol %h status %0d last %b",
                                          got.decoded_symbol, got.status, got.last));
                return;
            end
            want = expected_results.pop_front();
            if (got.decoded_symbol !== want.decoded_symbol)
                report_mismatch($sformatf("decoded_symbol %h, wanted %h",
                                          got.decoded_symbol, want.decoded_symbol));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b, wanted %b", got.last, want.last));
        endtask

        task check_drained();
            if (expected_results.size() != 0)
                report_mismatch($sformatf("%0d results never arrived",
                                          expected_results.size()));
        endtask
    endclass

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_stall;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    // idling percentages of the current phase
    int        send_idle_pct = 0;
    int        stall_pct     = 0;
    // set by the stimulus to ask the receiver for one long hold-off
    bit        hold_request  = 1'b0;

    code_tree_tracker tracker;

    huffman_tree_bit_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // transfer monitors: values sampled at the edge, ahead of any update
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            tracker.take_item(item);
        if (rst_n && result_valid && !result_stall)
            tracker.match_result(result);
    end

    // receiver: random stall, or one long hold-off when asked for
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
                result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog: too long without any transfer ends the run
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: %0d cycles without a transfer", QUIET_LIMIT);
        $display("tb_huffman_tree_bit_decoder NOT OK");
        $finish;
    end

    // load item; the unused byte field carries noise
    function automatic in_item_t load_item(logic [15:0] sym, logic [31:0] code,
                                           logic [5:0] len);
        in_item_t it;
        it.kind         = KIND_LOAD;
        it.symbol_value = sym;
        it.code_bits    = code;
        it.code_length  = len;
        it.data_byte    = 8'($urandom);
        return it;
    endfunction

    // decode item; the load fields carry noise
    function automatic in_item_t decode_item(logic [7:0] data);
        in_item_t it;
        it.kind         = KIND_DECODE;
        it.symbol_value = 16'($urandom);
        it.code_bits    = $urandom;
        it.code_length  = 6'($urandom);
        it.data_byte    = data;
        return it;
    endfunction

    // mostly short codes so the tree stays dense and decodes hit leaves
    function automatic in_item_t random_load();
        int         pick;
        logic [5:0] len;
        pick = $urandom_range(99);
        if (pick < 85)
            len = 6'($urandom_range(6, 1));
        else if (pick < 95)
            len = 6'($urandom_range(12, 7));
        else if (pick < 97)
            len = '0;
        else
            len = 6'($urandom_range(63, 32));
        return load_item(16'($urandom), $urandom, len);
    endfunction

    // one input transfer; valid stays high across back-to-back items
    task automatic send_item(input in_item_t it);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic run_random(input int idle_pct, input int hold_pct, input int count);
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        repeat (count)
        begin
            if ($urandom_range(99) < 45)
                send_item(random_load());
            else
                send_item(decode_item(8'($urandom)));
        end
    endtask

    initial
    begin : stimulus
        int fill_loads;
        tracker = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling
        // decode on an empty tree: bad path on every bit
        send_item(decode_item(8'hFF));
        // empty code leaves the tree unchanged and reports empty
        send_item(load_item(16'hFFFF, 32'hFFFF_FFFF, 6'd0));
        // full length code, then walked across several bytes
        send_item(load_item(16'hA5A5, 32'h5555_AAAA, 6'd32));
        send_item(decode_item(8'h55));
        send_item(decode_item(8'h55));
        send_item(decode_item(8'hAA));
        send_item(decode_item(8'hAA));
        // overlong lengths saturate
        send_item(load_item(16'h5A5A, 32'hFFFF_FFFF, 6'd33));
        send_item(load_item(16'h0F0F, 32'h8000_0001, 6'd63));
        // inner node turned into a leaf, then overwritten
        send_item(load_item(16'h0000, 32'h0000_0000, 6'd2));
        send_item(load_item(16'hFFFF, 32'h0000_0000, 6'd1));
        send_item(load_item(16'h8001, 32'h0000_0000, 6'd1));
        send_item(load_item(16'h1234, 32'h0000_0003, 6'd2));
        // load walking through an existing leaf
        send_item(load_item(16'h4321, 32'h0000_0006, 6'd3));
        send_item(decode_item(8'h00));
        send_item(decode_item(8'hFF));
        send_item(decode_item(8'hC3));
        // walk left deep in the tree, a load in between must not move it
        send_item(decode_item(8'h80));
        send_item(decode_item(8'h00));
        send_item(load_item(16'h7FFE, 32'h0000_0001, 6'd2));
        send_item(decode_item(8'h00));
        send_item(decode_item(8'h5A));
        // same path again, symbol overwritten without allocation
        send_item(load_item(16'h0000, 32'hFFFF_FFFF, 6'd32));
        send_item(decode_item(8'hFF));

        // receiver holds off while the sender keeps going
        hold_request = 1'b1;
        repeat (6)
        begin
            send_item(decode_item(8'h00));
            send_item(decode_item(8'($urandom)));
        end

        // random part over the idling phases
        run_random(0, 0, 50);
        run_random(76, 0, 50);
        run_random(0, 76, 50);
        run_random(17, 17, 50);

        // long random codes until the node table has reported full four times, at most 60 loads
        fill_loads = 0;
        while (tracker.full_seen < 4 && fill_loads < 60)
        begin
            send_item(load_item(16'($urandom), $urandom, 6'd32));
            fill_loads++;
        end
        run_random(17, 17, 10);

        item_valid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        tracker.check_drained();

        $display("run covered %0d input items: %0d codes loaded, %0d empty, %0d table full",
                 tracker.items_taken, tracker.loads_done, tracker.empties_seen,
                 tracker.full_seen);
        $display("decode produced %0d symbols and %0d bad paths, %0d mismatches",
                 tracker.symbols_seen, tracker.bad_paths_seen, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("tb_huffman_tree_bit_decoder OK");
        else
            $display("tb_huffman_tree_bit_decoder NOT OK");
        $finish;
    end

endmodule

[huffman_tree_bit_decoder.f]
rtl/htd_pkg.sv
rtl/htd_ram.sv
rtl/htd_ctrl.sv
rtl/htd_dpath.sv
rtl/huffman_tree_bit_decoder.sv
sim/tb_huffman_tree_bit_decoder.sv
